[hw/rtl/mvcc_pkg.sv]
package mvcc_pkg;

   localparam int MAX_VERSIONS_DEF = 16;
   localparam int MAX_ACTIVE_DEF   = 16;
   localparam int MAX_RESULTS      = 16;
   localparam int MAX_FREED        = MAX_RESULTS - 1;

   localparam logic [15:0] MAX_INLINE_RESET = 16'd4064;
   localparam logic [31:0] HEAD_NONE        = 32'hFFFF_FFFF;

   localparam int ROW_WIDTH = 31 + 2 + 31 + 32;

   typedef enum logic [2:0] {
      OP_APPEND       = 3'd0,
      OP_CLEAR_ACTIVE = 3'd1,
      OP_ADD_ACTIVE   = 3'd2,
      OP_FIND         = 3'd3,
      OP_PRUNE        = 3'd4,
      OP_HAS_VERSION  = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_HAS,
      ST_COUNT,
      ST_COMPACT
   } state_type;

   // One stored version as it sits in the table memory.
   typedef struct packed {
      logic [30:0] creator;
      logic        tomb;
      logic        ovf;
      logic [30:0] len;
      logic [31:0] head;
   } row_type;

endpackage

[hw/rtl/mvcc_version_chain_table_unit.sv]
// Channel        | Ports                                  | Transfer
// ---------------+----------------------------------------+------------------------------------
// request        | start, busy, req_*                     | rising edge with start and !busy
// response       | rsp_valid, rsp_*                       | every cycle rsp_valid is high
// configuration  | csr_valid, csr_ready, csr_data         | rising edge with valid and ready
//
// Append, clear active, add active and unknown operations answer in the cycle after the
// transfer and leave busy low. Find and has-version scan the table memory newest first, one
// entry per cycle through its single read port. Prune makes two passes over the stored
// versions, one to count the survivors and one to compact. Reset is synchronous and active
// high and empties both lists at once. The response side cannot stall; each result is shown
// for exactly one cycle.
module mvcc_version_chain_table_unit #(
   parameter int MAX_VERSIONS = mvcc_pkg::MAX_VERSIONS_DEF,
   parameter int MAX_ACTIVE   = mvcc_pkg::MAX_ACTIVE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [30:0] req_txid,
   input  logic        req_tombstone,
   input  logic        req_overflow,
   input  logic [30:0] req_value_len,
   input  logic [31:0] req_overflow_head,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic        rsp_found,
   output logic        rsp_tombstone_hit,
   output logic [3:0]  rsp_slot_index,
   output logic [30:0] rsp_found_len,
   output logic        rsp_found_overflow,
   output logic [31:0] rsp_head_page,
   output logic        rsp_freed,
   output logic [4:0]  rsp_version_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int IW  = $clog2(MAX_VERSIONS);
   localparam int CW  = $clog2(MAX_VERSIONS + 1);
   localparam int AIW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
   localparam int ACW = $clog2(MAX_ACTIVE + 1);
   localparam int FW  = $clog2(mvcc_pkg::MAX_FREED + 1);

   // Control and configuration registers.
   mvcc_pkg::state_type state_ff, state_in;
   logic [15:0]   max_inline_ff;
   logic [CW-1:0] vt_ff, vt_in;
   logic [ACW-1:0] at_ff, at_in;
   logic [30:0]   active_ff [MAX_ACTIVE];
   logic          act_wr;
   logic [30:0]   snap_ff, snap_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic [CW-1:0] w_ff, w_in;
   logic [FW-1:0] fcnt_ff, fcnt_in;

   // Response registers.
   logic        rv_ff, rv_in;
   logic        rok_ff, rok_in;
   logic        rfound_ff, rfound_in;
   logic        rtomb_ff, rtomb_in;
   logic [3:0]  rslot_ff, rslot_in;
   logic [30:0] rlen_ff, rlen_in;
   logic        rovf_ff, rovf_in;
   logic [31:0] rhead_ff, rhead_in;
   logic        rfreed_ff, rfreed_in;
   logic [4:0]  rcount_ff, rcount_in;
   logic        rlast_ff, rlast_in;

   // Table memory ports.
   logic             mem_wr;
   logic [IW-1:0]    mem_wr_addr;
   mvcc_pkg::row_type mem_wr_row, rd_row;
   logic [IW-1:0]    mem_rd_addr;
   logic [mvcc_pkg::ROW_WIDTH-1:0] rd_bits;

   mvcc_ram #(
      .WIDTH(mvcc_pkg::ROW_WIDTH),
      .DEPTH(MAX_VERSIONS)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_wr),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_row),
      .rd_addr(mem_rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_row = mvcc_pkg::row_type'(rd_bits);

   // The active list is compared against the entry at the memory output in parallel.
   logic [MAX_ACTIVE-1:0] blocked_v, seen_v;
   always_comb begin
      for (int k = 0; k < MAX_ACTIVE; k++) begin
         blocked_v[k] = (ACW'(k) < at_ff) && (active_ff[k] != snap_ff)
                        && (active_ff[k] == rd_row.creator);
         seen_v[k]    = (ACW'(k) < at_ff) && (rd_row.creator <= active_ff[k]);
      end
   end

   logic          visible, at_last;
   logic [CW-1:0] ptr_ext;
   logic [31:0]   ptr_wide, vt_in_wide, w_wide;
   logic          keep;
   logic          inline_long;

   assign ptr_ext     = CW'(ptr_ff);
   assign at_last     = (ptr_ext + CW'(1)) == n_ff;
   assign visible     = (rd_row.creator <= snap_ff) && !(|blocked_v);
   assign keep        = at_last || (|seen_v);
   assign ptr_wide    = 32'(ptr_ff);
   assign vt_in_wide  = 32'(vt_in);
   assign w_wide      = 32'(keep_ff);
   assign inline_long = !req_tombstone && !req_overflow
                        && (req_value_len > {15'd0, max_inline_ff});

   always_comb begin
      state_in    = state_ff;
      vt_in       = vt_ff;
      at_in       = at_ff;
      act_wr      = 1'b0;
      snap_in     = snap_ff;
      ptr_in      = ptr_ff;
      n_in        = n_ff;
      keep_in     = keep_ff;
      w_in        = w_ff;
      fcnt_in     = fcnt_ff;
      mem_wr      = 1'b0;
      mem_wr_addr = w_ff[IW-1:0];
      mem_wr_row  = rd_row;
      mem_rd_addr = ptr_ff;

      rv_in     = 1'b0;
      rok_in    = 1'b1;
      rfound_in = 1'b0;
      rtomb_in  = 1'b0;
      rslot_in  = 4'd0;
      rlen_in   = 31'd0;
      rovf_in   = 1'b0;
      rhead_in  = mvcc_pkg::HEAD_NONE;
      rfreed_in = 1'b0;
      rlast_in  = 1'b1;

      unique case (state_ff)
         mvcc_pkg::ST_IDLE: begin
            if (start) begin
               snap_in = req_txid;
               n_in    = vt_ff;
               priority case (req_op)
                  mvcc_pkg::OP_APPEND: begin
                     rv_in = 1'b1;
                     if ((vt_ff >= CW'(MAX_VERSIONS)) || inline_long) begin
                        rok_in = 1'b0;
                     end else begin
                        mem_wr              = 1'b1;
                        mem_wr_addr         = vt_ff[IW-1:0];
                        mem_wr_row.creator  = req_txid;
                        mem_wr_row.tomb     = req_tombstone;
                        mem_wr_row.ovf      = !req_tombstone && req_overflow;
                        mem_wr_row.len      = req_tombstone ? 31'd0 : req_value_len;
                        mem_wr_row.head     = (!req_tombstone && req_overflow)
                                              ? req_overflow_head : mvcc_pkg::HEAD_NONE;
                        vt_in               = vt_ff + CW'(1);
                     end
                  end
                  mvcc_pkg::OP_CLEAR_ACTIVE: begin
                     rv_in = 1'b1;
                     at_in = '0;
                  end
                  mvcc_pkg::OP_ADD_ACTIVE: begin
                     rv_in = 1'b1;
                     if (at_ff >= ACW'(MAX_ACTIVE)) begin
                        rok_in = 1'b0;
                     end else begin
                        act_wr = 1'b1;
                        at_in  = at_ff + ACW'(1);
                     end
                  end
                  mvcc_pkg::OP_FIND, mvcc_pkg::OP_HAS_VERSION: begin
                     if (vt_ff == '0) begin
                        rv_in = 1'b1;
                     end else begin
                        mem_rd_addr = IW'(vt_ff - CW'(1));
                        ptr_in      = IW'(vt_ff - CW'(1));
                        state_in    = (req_op == mvcc_pkg::OP_FIND)
                                      ? mvcc_pkg::ST_FIND : mvcc_pkg::ST_HAS;
                     end
                  end
                  mvcc_pkg::OP_PRUNE: begin
                     if (vt_ff <= CW'(1)) begin
                        rv_in = 1'b1;
                     end else begin
                        mem_rd_addr = '0;
                        ptr_in      = '0;
                        keep_in     = '0;
                        state_in    = mvcc_pkg::ST_COUNT;
                     end
                  end
                  default: begin
                     rv_in  = 1'b1;
                     rok_in = 1'b0;
                  end
               endcase
            end
         end

         mvcc_pkg::ST_FIND: begin
            if (visible) begin
               rv_in    = 1'b1;
               rslot_in = ptr_wide[3:0];
               state_in = mvcc_pkg::ST_IDLE;
               if (rd_row.tomb) begin
                  rtomb_in = 1'b1;
               end else begin
                  rfound_in = 1'b1;
                  rlen_in   = rd_row.len;
                  rovf_in   = rd_row.ovf;
                  rhead_in  = rd_row.head;
               end
            end else if (ptr_ff == '0) begin
               rv_in    = 1'b1;
               state_in = mvcc_pkg::ST_IDLE;
            end else begin
               mem_rd_addr = ptr_ff - IW'(1);
               ptr_in      = ptr_ff - IW'(1);
            end
         end

         mvcc_pkg::ST_HAS: begin
            if (rd_row.creator == snap_ff) begin
               rv_in     = 1'b1;
               rfound_in = 1'b1;
               state_in  = mvcc_pkg::ST_IDLE;
            end else if (ptr_ff == '0) begin
               rv_in    = 1'b1;
               state_in = mvcc_pkg::ST_IDLE;
            end else begin
               mem_rd_addr = ptr_ff - IW'(1);
               ptr_in      = ptr_ff - IW'(1);
            end
         end

         mvcc_pkg::ST_COUNT: begin
            keep_in = keep_ff + CW'(keep);
            if (at_last) begin
               mem_rd_addr = '0;
               ptr_in      = '0;
               w_in        = '0;
               fcnt_in     = '0;
               state_in    = mvcc_pkg::ST_COMPACT;
            end else begin
               mem_rd_addr = ptr_ff + IW'(1);
               ptr_in      = ptr_ff + IW'(1);
            end
         end

         mvcc_pkg::ST_COMPACT: begin
            if (keep) begin
               mem_wr = 1'b1;
               w_in   = w_ff + CW'(1);
            end else if (rd_row.ovf && !rd_row.head[31]
                         && (fcnt_ff < FW'(mvcc_pkg::MAX_FREED))) begin
               rv_in     = 1'b1;
               rhead_in  = rd_row.head;
               rfreed_in = 1'b1;
               rlast_in  = 1'b0;
               fcnt_in   = fcnt_ff + FW'(1);
            end
            // The newest entry is always kept, so the status result never meets a freed one.
            if (at_last) begin
               vt_in    = keep_ff;
               rv_in    = 1'b1;
               state_in = mvcc_pkg::ST_IDLE;
            end else begin
               mem_rd_addr = ptr_ff + IW'(1);
               ptr_in      = ptr_ff + IW'(1);
            end
         end

         default: begin
            state_in = mvcc_pkg::ST_IDLE;
         end
      endcase

      // Freed reports during compaction already carry the final count.
      rcount_in = (state_ff == mvcc_pkg::ST_COMPACT) ? w_wide[4:0] : vt_in_wide[4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mvcc_pkg::ST_IDLE;
         max_inline_ff <= mvcc_pkg::MAX_INLINE_RESET;
         vt_ff         <= '0;
         at_ff         <= '0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff <= state_in;
         vt_ff    <= vt_in;
         at_ff    <= at_in;
         rv_ff    <= rv_in;
         if (csr_valid) begin
            max_inline_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (act_wr) begin
         active_ff[at_ff[AIW-1:0]] <= req_txid;
      end
      snap_ff   <= snap_in;
      ptr_ff    <= ptr_in;
      n_ff      <= n_in;
      keep_ff   <= keep_in;
      w_ff      <= w_in;
      fcnt_ff   <= fcnt_in;
      rok_ff    <= rok_in;
      rfound_ff <= rfound_in;
      rtomb_ff  <= rtomb_in;
      rslot_ff  <= rslot_in;
      rlen_ff   <= rlen_in;
      rovf_ff   <= rovf_in;
      rhead_ff  <= rhead_in;
      rfreed_ff <= rfreed_in;
      rcount_ff <= rcount_in;
      rlast_ff  <= rlast_in;
   end

   assign busy               = (state_ff != mvcc_pkg::ST_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rv_ff;
   assign rsp_ok             = rok_ff;
   assign rsp_found          = rfound_ff;
   assign rsp_tombstone_hit  = rtomb_ff;
   assign rsp_slot_index     = rslot_ff;
   assign rsp_found_len      = rlen_ff;
   assign rsp_found_overflow = rovf_ff;
   assign rsp_head_page      = rhead_ff;
   assign rsp_freed          = rfreed_ff;
   assign rsp_version_count  = rcount_ff;
   assign rsp_last           = rlast_ff;

`ifndef SYNTH
   a_nonlast_is_freed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_freed)
      else $error("non-final result does not report a freed page");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      vt_ff <= CW'(MAX_VERSIONS))
      else $error("version count beyond table depth");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_op == mvcc_pkg::OP_APPEND) && (vt_ff == CW'(MAX_VERSIONS))
      |=> rsp_valid && !rsp_ok && $stable(vt_ff))
      else $error("append into a full table was not rejected");
`endif

endmodule

[hw/rtl/mvcc_ram.sv]
module mvcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/tb_top.sv]
module tb_top;

   // Operation codes that the block does not define; they must be refused without side effects.
   localparam mvcc_pkg::op_type OP_RESERVED_6 = mvcc_pkg::op_type'(3'd6);
   localparam mvcc_pkg::op_type OP_RESERVED_7 = mvcc_pkg::op_type'(3'd7);
   localparam int     TABLE_DEPTH   = mvcc_pkg::MAX_VERSIONS_DEF;
   localparam int     ACTIVE_DEPTH  = mvcc_pkg::MAX_ACTIVE_DEF;
   // Longest quiet spell that the block may still spend on an operation after its last result.
   localparam int     DRAIN_CYCLES  = 4 * TABLE_DEPTH + 8;
   localparam int     RANDOM_ITEMS  = 165;

   // One result as the response channel presents it.
   typedef struct packed {
      logic        ok;
      logic        found;
      logic        tomb_hit;
      logic [3:0]  slot;
      logic [30:0] len;
      logic        ovf;
      logic [31:0] head;
      logic        freed;
      logic [4:0]  count;
      logic        last;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [30:0] req_txid;
   logic        req_tombstone;
   logic        req_overflow;
   logic [30:0] req_value_len;
   logic [31:0] req_overflow_head;
   logic        rsp_valid;
   logic        rsp_ok;
   logic        rsp_found;
   logic        rsp_tombstone_hit;
   logic [3:0]  rsp_slot_index;
   logic [30:0] rsp_found_len;
   logic        rsp_found_overflow;
   logic [31:0] rsp_head_page;
   logic        rsp_freed;
   logic [4:0]  rsp_version_count;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   mvcc_version_chain_table_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_txid           (req_txid),
      .req_tombstone      (req_tombstone),
      .req_overflow       (req_overflow),
      .req_value_len      (req_value_len),
      .req_overflow_head  (req_overflow_head),
      .rsp_valid          (rsp_valid),
      .rsp_ok             (rsp_ok),
      .rsp_found          (rsp_found),
      .rsp_tombstone_hit  (rsp_tombstone_hit),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_found_len      (rsp_found_len),
      .rsp_found_overflow (rsp_found_overflow),
      .rsp_head_page      (rsp_head_page),
      .rsp_freed          (rsp_freed),
      .rsp_version_count  (rsp_version_count),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   // Shadow copy of the version table, the active list and the inline limit. It is updated at
   // the moment each request transfer is accepted, in the same order as the block sees them.
   logic [30:0] shadow_creator [TABLE_DEPTH];
   logic        shadow_tomb    [TABLE_DEPTH];
   logic        shadow_ovf     [TABLE_DEPTH];
   logic [30:0] shadow_len     [TABLE_DEPTH];
   logic [31:0] shadow_head    [TABLE_DEPTH];
   int          shadow_versions;
   logic [30:0] shadow_active  [ACTIVE_DEPTH];
   int          shadow_active_total;
   logic [15:0] shadow_inline_limit;

   outcome_type pending_outcomes [$];
   int          mismatch_count;
   bit          calm_stretch;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Queues one expected result; the version count is always the one held after the operation.
   function automatic void expect_outcome(logic ok, logic found, logic tomb_hit,
                                          logic [3:0] slot, logic [30:0] len, logic ovf,
                                          logic [31:0] head, logic freed, logic last);
      outcome_type o;
      o.ok = ok; o.found = found; o.tomb_hit = tomb_hit; o.slot = slot; o.len = len;
      o.ovf = ovf; o.head = head; o.freed = freed; o.count = 5'(shadow_versions);
      o.last = last;
      pending_outcomes.push_back(o);
   endfunction

   // True when the creator is still running from the point of view of the given snapshot. An
   // active entry equal to the snapshot itself is the reader, so it is passed over.
   function automatic bit hidden_by_active(logic [30:0] creator, logic [30:0] snapshot);
      for (int k = 0; k < shadow_active_total; k++) begin
         if (shadow_active[k] != snapshot && shadow_active[k] == creator) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the results that one accepted request causes and advances the shadow state.
   function automatic void predict_table_op(logic [2:0] op, logic [30:0] txid, logic tomb,
                                            logic ovf, logic [30:0] vlen, logic [31:0] head);
      int          n;
      int          kept;
      int          reports;
      bit          keep;
      bit          hit;
      logic [31:0] freed_heads [$];
      n = shadow_versions;
      case (op)
         mvcc_pkg::OP_APPEND: begin
            if (n >= TABLE_DEPTH || (!tomb && !ovf && vlen > 31'(shadow_inline_limit))) begin
               expect_outcome(0, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
            end else begin
               // A tombstone wins over the overflow mark; inline rows never keep a head page.
               shadow_creator[n] = txid;
               shadow_tomb[n]    = tomb;
               shadow_ovf[n]     = !tomb && ovf;
               shadow_len[n]     = tomb ? 31'd0 : vlen;
               shadow_head[n]    = (!tomb && ovf) ? head : mvcc_pkg::HEAD_NONE;
               shadow_versions   = n + 1;
               expect_outcome(1, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
            end
         end
         mvcc_pkg::OP_CLEAR_ACTIVE: begin
            shadow_active_total = 0;
            expect_outcome(1, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
         end
         mvcc_pkg::OP_ADD_ACTIVE: begin
            if (shadow_active_total >= ACTIVE_DEPTH) begin
               expect_outcome(0, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
            end else begin
               shadow_active[shadow_active_total] = txid;
               shadow_active_total++;
               expect_outcome(1, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
            end
         end
         mvcc_pkg::OP_FIND: begin
            // Newest first; the first visible row decides, and a tombstone ends the search.
            for (int s = n - 1; s >= 0; s--) begin
               if (shadow_creator[s] <= txid && !hidden_by_active(shadow_creator[s], txid)) begin
                  if (shadow_tomb[s])
                     expect_outcome(1, 0, 1, 4'(s), 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
                  else
                     expect_outcome(1, 1, 0, 4'(s), shadow_len[s], shadow_ovf[s],
                                    shadow_head[s], 0, 1);
                  return;
               end
            end
            expect_outcome(1, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
         end
         mvcc_pkg::OP_PRUNE: begin
            if (n > 1) begin
               kept = 0;
               for (int i = 0; i < n; i++) begin
                  keep = (i == n - 1);
                  for (int k = 0; k < shadow_active_total; k++)
                     if (shadow_creator[i] <= shadow_active[k]) keep = 1'b1;
                  if (keep) begin
                     shadow_creator[kept] = shadow_creator[i];
                     shadow_tomb[kept]    = shadow_tomb[i];
                     shadow_ovf[kept]     = shadow_ovf[i];
                     shadow_len[kept]     = shadow_len[i];
                     shadow_head[kept]    = shadow_head[i];
                     kept++;
                  end else if (shadow_ovf[i] && !shadow_head[i][31]) begin
                     // Only a real page chain is handed back for freeing.
                     freed_heads.push_back(shadow_head[i]);
                  end
               end
               shadow_versions = kept;
            end
            reports = 0;
            foreach (freed_heads[i]) begin
               if (reports < mvcc_pkg::MAX_FREED) begin
                  expect_outcome(1, 0, 0, 0, 0, 0, freed_heads[i], 1, 0);
                  reports++;
               end
            end
            expect_outcome(1, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
         end
         mvcc_pkg::OP_HAS_VERSION: begin
            hit = 1'b0;
            for (int i = 0; i < n; i++)
               if (shadow_creator[i] == txid) hit = 1'b1;
            expect_outcome(1, hit, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
         end
         default: begin
            expect_outcome(0, 0, 0, 0, 0, 0, mvcc_pkg::HEAD_NONE, 0, 1);
         end
      endcase
   endfunction

   // Every strobed result is taken at the rising edge that ends its cycle and matched against
   // the oldest expectation.
   always @(posedge clock) begin
      outcome_type seen;
      outcome_type want;
      if (!reset && rsp_valid) begin
         seen = {rsp_ok, rsp_found, rsp_tombstone_hit, rsp_slot_index, rsp_found_len,
                 rsp_found_overflow, rsp_head_page, rsp_freed, rsp_version_count, rsp_last};
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: ok %0d found %0d head %h count %0d last %0d",
                        seen.ok, seen.found, seen.head, seen.count, seen.last);
         end else begin
            want = pending_outcomes.pop_front();
            if (seen !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result mismatch (expected / actual): ok %0d/%0d found %0d/%0d ",
                            "tomb %0d/%0d slot %0d/%0d len %0d/%0d ovf %0d/%0d head %h/%h ",
                            "freed %0d/%0d count %0d/%0d last %0d/%0d"},
                           want.ok, seen.ok, want.found, seen.found, want.tomb_hit,
                           seen.tomb_hit, want.slot, seen.slot, want.len, seen.len, want.ovf,
                           seen.ovf, want.head, seen.head, want.freed, seen.freed, want.count,
                           seen.count, want.last, seen.last);
            end
         end
      end
   end

   // Sends one request. The sender holds off now and then so that gaps land on every phase of
   // the block's work, except during the calm stretch of the random traffic. The prediction is
   // made at the edge where the transfer happens.
   task automatic send_request(mvcc_pkg::op_type op, logic [30:0] txid, logic tomb = 1'b0,
                               logic ovf = 1'b0, logic [30:0] vlen = '0,
                               logic [31:0] head = mvcc_pkg::HEAD_NONE);
      @(negedge clock);
      if (!calm_stretch && $urandom_range(99) < 29) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_op            <= op;
      req_txid          <= txid;
      req_tombstone     <= tomb;
      req_overflow      <= ovf;
      req_value_len     <= vlen;
      req_overflow_head <= head;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
      predict_table_op(op, txid, tomb, ovf, vlen, head);
   endtask

   // Changes the inline limit once the block has gone quiet: all results in, then a pause long
   // enough for any scan still running to finish.
   task automatic write_inline_limit(logic [15:0] limit);
      @(negedge clock);
      start <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      shadow_inline_limit = limit;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Length checks at the reset limit and at both extremes of the register, the tombstone and
   // overflow marks, and a table filled up until it refuses further appends.
   task automatic test_append_limits;
      send_request(mvcc_pkg::OP_APPEND, 31'd0, 0, 0, 31'd4064, 32'h0000_1234);
      send_request(mvcc_pkg::OP_APPEND, 31'd1, 0, 0, 31'd4065);
      send_request(mvcc_pkg::OP_APPEND, 31'd2, 1, 1, 31'h7FFF_FFFF, 32'h0000_0042);
      send_request(mvcc_pkg::OP_APPEND, 31'h7FFF_FFFF, 0, 1, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
      write_inline_limit(16'd0);
      send_request(mvcc_pkg::OP_APPEND, 31'd3, 0, 0, 31'd0, 32'h8000_0000);
      send_request(mvcc_pkg::OP_APPEND, 31'd4, 0, 0, 31'd1);
      write_inline_limit(16'hFFFF);
      send_request(mvcc_pkg::OP_APPEND, 31'd5, 0, 0, 31'd65535);
      send_request(mvcc_pkg::OP_APPEND, 31'd6, 0, 0, 31'd65536);
      // Fill the rest of the table with overflow rows, some without a page chain.
      while (shadow_versions < TABLE_DEPTH)
         send_request(mvcc_pkg::OP_APPEND, 31'(10 + shadow_versions), 0, 1, 31'($urandom),
                      shadow_versions[0] ? 32'hFFFF_FFF0 : 32'(100 + shadow_versions));
      send_request(mvcc_pkg::OP_APPEND, 31'd7, 0, 0, 31'd8);
   endtask

   // Fills the active list past its end, then looks up with a snapshot that is itself active.
   task automatic test_active_list;
      for (int k = 0; k <= ACTIVE_DEPTH; k++)
         send_request(mvcc_pkg::OP_ADD_ACTIVE, (k == 0) ? 31'h7FFF_FFFF : 31'(k + 9));
      send_request(mvcc_pkg::OP_FIND, 31'd12);
      send_request(mvcc_pkg::OP_FIND, 31'h7FFF_FFFF);
      send_request(mvcc_pkg::OP_CLEAR_ACTIVE, 31'd0);
   endtask

   // Visibility with an empty list and with a running writer, and the has-version lookup.
   task automatic test_find_visibility;
      send_request(mvcc_pkg::OP_FIND, 31'd0);
      send_request(mvcc_pkg::OP_FIND, 31'd2);
      send_request(mvcc_pkg::OP_FIND, 31'h7FFF_FFFE);
      send_request(mvcc_pkg::OP_ADD_ACTIVE, 31'd25);
      send_request(mvcc_pkg::OP_FIND, 31'd30);
      send_request(mvcc_pkg::OP_HAS_VERSION, 31'd25);
      send_request(mvcc_pkg::OP_HAS_VERSION, 31'd9);
   endtask

   // A prune that keeps the rows seen by an old snapshot, one that drops everything but the
   // newest row, and a prune of a single row.
   task automatic test_prune;
      send_request(mvcc_pkg::OP_ADD_ACTIVE, 31'd14);
      send_request(mvcc_pkg::OP_PRUNE, 31'd0);
      send_request(mvcc_pkg::OP_CLEAR_ACTIVE, 31'd0);
      send_request(mvcc_pkg::OP_PRUNE, 31'd0);
      send_request(mvcc_pkg::OP_PRUNE, 31'd0);
      send_request(mvcc_pkg::OP_FIND, 31'h7FFF_FFFF);
   endtask

   task automatic test_unknown_ops;
      send_request(OP_RESERVED_6, 31'h5555_5555, 1, 1, 31'h2AAA_AAAA, 32'hAAAA_AAAA);
      send_request(OP_RESERVED_7, 31'h2AAA_AAAA);
   endtask

   // Mostly coherent traffic over a small id space so that lookups, hidden writers and prune
   // drops really happen; a share of items use the full field ranges.
   task automatic test_random_traffic;
      int          pick;
      logic [30:0] id;
      logic [30:0] vlen;
      logic [31:0] head;
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == 70) write_inline_limit(16'($urandom_range(0, 8000)));
         if (item == 150) write_inline_limit(16'hFFFF);
         calm_stretch = (item >= 90 && item < 130);
         pick = $urandom_range(99);
         id   = ($urandom_range(99) < 85) ? 31'($urandom_range(0, 40)) : 31'($urandom);
         vlen = ($urandom_range(99) < 80) ? 31'($urandom_range(0, 4200)) : 31'($urandom);
         case ($urandom_range(5))
            0:       head = $urandom | 32'h8000_0000;
            1:       head = $urandom;
            default: head = 32'($urandom_range(0, 5000));
         endcase
         if (pick < 40)
            send_request(mvcc_pkg::OP_APPEND, id, $urandom_range(99) < 15, $urandom_range(1),
                         vlen, head);
         else if (pick < 62)
            send_request(mvcc_pkg::OP_FIND, id);
         else if (pick < 73)
            send_request(mvcc_pkg::OP_ADD_ACTIVE, id);
         else if (pick < 78)
            send_request(mvcc_pkg::OP_CLEAR_ACTIVE, id);
         else if (pick < 89)
            send_request(mvcc_pkg::OP_PRUNE, id);
         else if (pick < 97)
            send_request(mvcc_pkg::OP_HAS_VERSION, id);
         else
            send_request($urandom_range(1) ? OP_RESERVED_6 : OP_RESERVED_7, id, 1, 1, vlen,
                         head);
      end
      calm_stretch = 1'b0;
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_op              = mvcc_pkg::OP_APPEND;
      req_txid            = '0;
      req_tombstone       = 1'b0;
      req_overflow        = 1'b0;
      req_value_len       = '0;
      req_overflow_head   = '0;
      csr_valid           = 1'b0;
      csr_data            = '0;
      shadow_versions     = 0;
      shadow_active_total = 0;
      shadow_inline_limit = mvcc_pkg::MAX_INLINE_RESET;
      mismatch_count      = 0;
      calm_stretch        = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_append_limits();
      test_active_list();
      test_find_visibility();
      test_prune();
      test_unknown_ops();
      test_random_traffic();

      @(negedge clock);
      start <= 1'b0;
      wait (pending_outcomes.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

   // Far beyond the slowest correct run of a few hundred items.
   initial begin
      #(8 * 400000);
      $display("tb_top failed");
      $finish;
   end

endmodule
